// ----- hw/rtl/lis_pkg.sv -----
// Package for the integer literal scanner: codes, state types and character decode.
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

  // Scan phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // Radix codes as reported with a result
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_OVF   = 2'd2
  } status_t;

  // Character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_B    = 8'h62;
  localparam logic [7:0] CH_UP_B    = 8'h42;

  // Digit values are 0..15; this code marks a non-digit
  localparam logic [4:0] NO_DIGIT   = 5'd16;

  // Scanner control state
  typedef struct packed {
    phase_t phase;
    radix_t radix;
    logic   ovf;
  } ctl_t;

  // Per-request step outcome
  typedef struct packed {
    logic    emit;
    radix_t  radix;
    status_t status;
  } res_t;

  // Decode a character into its digit value, NO_DIGIT if it is none
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
      return d[4:0];
    end
    if (c inside {[CH_LO_A:CH_LO_F]}) begin
      d = c - CH_LO_A + 8'd10;
      return d[4:0];
    end
    if (c inside {[CH_UP_A:CH_UP_F]}) begin
      d = c - CH_UP_A + 8'd10;
      return d[4:0];
    end
    return NO_DIGIT;
  endfunction

  // Numeric base of a radix code
  function automatic logic [4:0] base_of(input radix_t r);
    case (r)
      RADIX_DEC: return 5'd10;
      RADIX_HEX: return 5'd16;
      RADIX_OCT: return 5'd8;
      RADIX_BIN: return 5'd2;
      default:   return 5'd10;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lis_if.sv -----
// Valid/ready channel interfaces for scanner characters and scan results.
`timescale 1ns / 1ps
`default_nettype none

interface lis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface lis_out_if #(
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [1:0]            radix;
  logic [1:0]            status;

  modport source (output valid, output value, output radix, output status, input ready);
  modport sink   (input valid, input value, input radix, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lis_step.sv -----
// One scan step: next scanner state and optional result for one character.
`timescale 1ns / 1ps
`default_nettype none

module lis_step #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic [7:0]            ch,
  input  wire logic                  first,
  input  wire lis_pkg::ctl_t         ctl,
  input  wire logic [VALUE_BITS-1:0] acc,
  output lis_pkg::ctl_t              ctl_nxt,
  output logic [VALUE_BITS-1:0]      acc_nxt,
  output lis_pkg::res_t              res,
  output logic [VALUE_BITS-1:0]      value
);
  import lis_pkg::*;

  // Product width: acc * 16 + 15 fits with headroom
  localparam int PW = VALUE_BITS + 5;

  logic                  take;
  radix_t                radix_e;
  logic                  ovf_e;
  logic [VALUE_BITS-1:0] acc_e;
  logic [4:0]            d;
  logic [4:0]            base;
  logic [PW-1:0]         acc_w;
  logic [PW-1:0]         prod;
  logic                  prod_ovf;
  ctl_t                  ctl_pre;
  logic                  ovf_set;

  assign d    = digit_value(ch);
  assign base = base_of(radix_e);

  // acc * base + d as shifts and adds
  assign acc_w = {5'd0, acc_e};
  always_comb begin
    case (radix_e)
      RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
      RADIX_HEX: prod = acc_w << 4;
      RADIX_OCT: prod = acc_w << 3;
      RADIX_BIN: prod = acc_w << 1;
      default:   prod = acc_w;
    endcase
    prod = prod + {{(PW-5){1'b0}}, d};
  end
  assign prod_ovf = |prod[PW-1:VALUE_BITS];

  // Prefix handling: decide effective base and whether the char is a digit candidate
  always_comb begin
    take        = 1'b0;
    radix_e     = ctl.radix;
    ovf_e       = ctl.ovf;
    acc_e       = acc;
    ctl_pre     = ctl;
    if (first) begin
      acc_e   = '0;
      radix_e = RADIX_DEC;
      ovf_e   = 1'b0;
      if (ch == CH_ZERO) begin
        ctl_pre.phase = PH_ZERO;
      end else begin
        ctl_pre.phase = PH_DIGITS;
        take          = 1'b1;
      end
    end else begin
      case (ctl.phase)
        PH_ZERO: begin
          ctl_pre.phase = PH_DIGITS;
          if (ch == CH_LO_X || ch == CH_UP_X) begin
            radix_e = RADIX_HEX;
          end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
            radix_e = RADIX_OCT;
            take    = 1'b1;
          end else if (ch == CH_LO_B || ch == CH_UP_B) begin
            radix_e = RADIX_BIN;
          end else begin
            radix_e = RADIX_DEC;
            take    = 1'b1;
          end
        end
        PH_DIGITS: take = 1'b1;
        default:   take = 1'b0;
      endcase
    end
    ctl_pre.radix = radix_e;
    ctl_pre.ovf   = ovf_e;
  end

  // Digit accumulation and literal end
  always_comb begin
    acc_nxt    = acc_e;
    res.emit   = 1'b0;
    res.radix  = radix_e;
    res.status = STAT_OK;
    value      = acc_e;
    if (take) begin
      if (ovf_e) begin
        if (d >= base) begin
          acc_nxt    = '0;
          value      = '0;
          res.emit   = 1'b1;
          res.status = STAT_OVF;
        end
      end else if (d == NO_DIGIT) begin
        res.emit = 1'b1;
      end else if (d >= base) begin
        res.emit   = 1'b1;
        res.status = STAT_RANGE;
      end else if (prod_ovf) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = prod[VALUE_BITS-1:0];
      end
    end
  end

  assign ovf_set = take && !ovf_e && (d != NO_DIGIT) && (d < base) && prod_ovf;

  // Overflow flag and phase after the step
  always_comb begin
    ctl_nxt = ctl_pre;
    if (res.emit) begin
      ctl_nxt.phase = PH_IDLE;
    end else if (ovf_set) begin
      ctl_nxt.ovf = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/integer_literal_scanner_top.sv -----
// Top level of the integer literal scanner: input stage, scan step, result register.
// The input stage and the result register lie between a character and its result.
// Throughput: one character per cycle while the result register is not stalled.
// A stalled result register holds the input stage, which then holds in_chan.ready low.
// Reset (rst_n low, synchronous): phase idle, radix decimal, no overflow, stages empty.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_scanner_top #(
  parameter int VALUE_BITS = 64
) (
  input wire logic    clk,
  input wire logic    rst_n,
  lis_in_if.sink      in_chan,
  lis_out_if.source   out_chan
);
  import lis_pkg::*;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_first_r;

  // Scanner state
  ctl_t                  ctl_r;
  ctl_t                  ctl_nxt;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;

  // Result register
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  radix_t                out_radix_r;
  status_t               out_status_r;

  res_t                  res;
  logic [VALUE_BITS-1:0] step_value;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.radix  = out_radix_r;
  assign out_chan.status = out_status_r;

  lis_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .ch      (s1_ch_r),
    .first   (s1_first_r),
    .ctl     (ctl_r),
    .acc     (acc_r),
    .ctl_nxt (ctl_nxt),
    .acc_nxt (acc_nxt),
    .res     (res),
    .value   (step_value)
  );

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_ch_r    <= in_chan.ch;
      s1_first_r <= in_chan.first;
    end
  end

  // Scanner state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{phase: PH_IDLE, radix: RADIX_DEC, ovf: 1'b0};
      acc_r <= '0;
    end else if (s1_fire) begin
      ctl_r <= ctl_nxt;
      acc_r <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res.emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && res.emit) begin
      out_value_r  <= step_value;
      out_radix_r  <= res.radix;
      out_status_r <= res.status;
    end
  end

  // Assertions
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  a_no_step_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !s1_fire)
    else $error("scan step taken while result register stalled");

  a_ovf_clears_acc : assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.ovf |-> (acc_r == '0))
    else $error("accumulator not zero after overflow");

  a_ovf_value_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_OVF) |-> (out_value_r == '0))
    else $error("overflow result with nonzero value");

endmodule

`default_nettype wire

// ----- sim/lis_scan_checker.sv -----
// Scoreboard for the integer literal scanner: predicts results from requests and checks them.
`timescale 1ns / 1ps

module lis_scan_checker (
  input  logic clk,
  input  logic rst_n,
  lis_in_if    in_mon,
  lis_out_if   out_mon,
  output int   errors,
  output int   pending
);

  import lis_pkg::*;

  localparam logic [63:0] VALUE_MAX = {64{1'b1}};

  typedef struct packed {
    logic [63:0] value;
    radix_t      radix;
    status_t     status;
  } lit_result_t;

  // Results still owed by the scanner, oldest first
  lit_result_t lit_due[$];

  // Shadow copy of the scanner state
  phase_t      scan_phase;
  logic [63:0] scan_acc;
  radix_t      scan_radix;
  logic        scan_ovf;
  int          mismatch_cnt = 0;

  // Digit value of a character, NO_DIGIT when it is not a digit
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      return t[4:0];
    end
    if (c >= CH_LO_A && c <= CH_LO_F) begin
      t = c - CH_LO_A + 8'd10;
      return t[4:0];
    end
    if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
      return t[4:0];
    end
    return NO_DIGIT;
  endfunction

  function automatic logic [63:0] radix_base(input radix_t r);
    case (r)
      RADIX_HEX: return 64'd16;
      RADIX_OCT: return 64'd8;
      RADIX_BIN: return 64'd2;
      default:   return 64'd10;
    endcase
  endfunction

  // Literal ends: queue its result and go idle
  task automatic close_literal(input status_t st);
    lit_result_t r;
    r.value  = scan_acc;
    r.radix  = scan_radix;
    r.status = st;
    lit_due.push_back(r);
    scan_phase = PH_IDLE;
  endtask

  // One character inside the digit loop of the current base
  task automatic take_digit(input logic [7:0] c);
    logic [63:0] base;
    logic [63:0] dig;
    base = radix_base(scan_radix);
    dig  = {59'd0, char_digit(c)};
    if (scan_ovf) begin
      // after overflow, valid digits are swallowed; anything else ends it
      if (dig >= base) begin
        scan_acc = '0;
        close_literal(STAT_OVF);
      end
    end else if (dig == {59'd0, NO_DIGIT}) begin
      close_literal(STAT_OK);
    end else if (dig >= base) begin
      close_literal(STAT_RANGE);
    end else if (scan_acc > (VALUE_MAX - dig) / base) begin
      scan_ovf = 1'b1;
      scan_acc = '0;
    end else begin
      scan_acc = scan_acc * base + dig;
    end
  endtask

  // Advance the shadow scanner by one accepted request
  task automatic advance_scan(input logic [7:0] c, input logic f);
    if (f) begin
      scan_acc   = '0;
      scan_radix = RADIX_DEC;
      scan_ovf   = 1'b0;
      if (c == CH_ZERO) begin
        scan_phase = PH_ZERO;
      end else begin
        scan_phase = PH_DIGITS;
        take_digit(c);
      end
    end else if (scan_phase == PH_ZERO) begin
      // character after a leading zero picks the base
      scan_phase = PH_DIGITS;
      if (c == CH_LO_X || c == CH_UP_X) begin
        scan_radix = RADIX_HEX;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        scan_radix = RADIX_OCT;
        take_digit(c);
      end else if (c == CH_LO_B || c == CH_UP_B) begin
        scan_radix = RADIX_BIN;
      end else begin
        scan_radix = RADIX_DEC;
        take_digit(c);
      end
    end else if (scan_phase == PH_DIGITS) begin
      take_digit(c);
    end
  endtask

  // Compare results, then predict from the request taken at the same edge
  always @(posedge clk) begin : scan_check
    lit_result_t want;
    if (!rst_n) begin
      scan_phase = PH_IDLE;
      scan_acc   = '0;
      scan_radix = RADIX_DEC;
      scan_ovf   = 1'b0;
      lit_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (lit_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result value %h radix %0d status %0d",
                     $realtime, out_mon.value, out_mon.radix, out_mon.status);
        end else begin
          want = lit_due.pop_front();
          if (out_mon.value !== want.value || out_mon.radix !== want.radix ||
              out_mon.status !== want.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: result mismatch: value exp %h got %h, radix exp %0d got %0d, %s",
                       $realtime, want.value, out_mon.value, want.radix, out_mon.radix,
                       $sformatf("status exp %0d got %0d", want.status, out_mon.status));
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        advance_scan(in_mon.ch, in_mon.first);
    end
    pending <= lit_due.size();
    errors  <= mismatch_cnt;
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the integer literal scanner: clock, reset, traffic and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   chars_sent = 0;
  bit   no_idle = 1'b0;
  bit   paused = 1'b0;

  lis_in_if in_chan ();
  lis_out_if #(.VALUE_BITS(64)) out_chan ();

  integer_literal_scanner_top #(.VALUE_BITS(64)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lis_scan_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .errors  (fail_count),
    .pending (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the scanner hangs
  initial begin
    #2_000_000;
    $display("[integer_literal_scanner_top] ERROR");
    $finish;
  end

  // Result side: random stall before taking each result
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(negedge clk); while (!out_chan.valid);
      @(posedge clk);
    end
  end

  // One request; returns at the edge that accepts it
  task automatic send_char(input logic [7:0] c, input logic f, input bit ignored);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.first <= f;
    do @(negedge clk); while (!in_chan.ready);
    @(posedge clk);
    if (!ignored) chars_sent++;
  endtask

  // Stop sending until every owed result is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A literal of random base and length, or a lone random first character, then some way of ending it
  task automatic send_literal();
    int          kind;
    int          n;
    int          d;
    logic [7:0]  c;
    string       lead;
    string       bad_digits;
    string       puncts;
    lead       = "1844674407370955161";
    bad_digits = "89aFgZ";
    puncts     = " ,;)";
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 26) : $urandom_range(0, 5);
    case (kind)
      0, 1, 2: begin
        c = 8'("1" + $urandom_range(0, 8));
        send_char(c, 1'b1, 1'b0);
        repeat (n) begin
          c = 8'("0" + $urandom_range(0, 9));
          send_char(c, 1'b0, 1'b0);
        end
      end
      3, 4: begin
        send_char("0", 1'b1, 1'b0);
        send_char($urandom_range(0, 1) ? "x" : "X", 1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          // right at the 64-bit limit, or one digit past it
          repeat (16 + $urandom_range(0, 1))
            send_char($urandom_range(0, 1) ? "f" : "F", 1'b0, 1'b0);
        end else begin
          repeat (n) begin
            d = $urandom_range(0, 15);
            if (d < 10) c = 8'("0" + d);
            else c = 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
            send_char(c, 1'b0, 1'b0);
          end
        end
      end
      5: begin
        send_char("0", 1'b1, 1'b0);
        repeat (n) begin
          c = 8'("0" + $urandom_range(0, 7));
          send_char(c, 1'b0, 1'b0);
        end
      end
      6: begin
        send_char("0", 1'b1, 1'b0);
        send_char($urandom_range(0, 1) ? "b" : "B", 1'b0, 1'b0);
        if ($urandom_range(0, 4) == 0) begin
          // long run with a leading one: 63 to 66 digits, overflowing only past 64
          send_char("1", 1'b0, 1'b0);
          n = 62 + $urandom_range(0, 3);
        end
        repeat (n) begin
          c = 8'("0" + $urandom_range(0, 1));
          send_char(c, 1'b0, 1'b0);
        end
      end
      7: begin
        // decimal near the maximum value
        for (int i = 0; i < lead.len(); i++)
          send_char(lead[i], i == 0, 1'b0);
        case ($urandom_range(0, 2))
          0:       send_char("5", 1'b0, 1'b0);
          1:       send_char("6", 1'b0, 1'b0);
          default: send_char("9", 1'b0, 1'b0);
        endcase
        repeat ($urandom_range(0, 2)) begin
          c = 8'("0" + $urandom_range(0, 9));
          send_char(c, 1'b0, 1'b0);
        end
      end
      8: send_char("0", 1'b1, 1'b0);
      default: send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    endcase
    // how the literal ends
    case ($urandom_range(0, 5))
      0, 1, 2: send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      3:       send_char(bad_digits[$urandom_range(0, 5)], 1'b0, 1'b0);
      4:       ;  // next literal restarts this one
      default: begin
        send_char(puncts[$urandom_range(0, 3)], 1'b0, 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    in_chan.valid <= 1'b0;
    in_chan.ch    <= 8'd0;
    in_chan.first <= 1'b0;
    rst_n         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // prefix only
    send_char("0", 1'b1, 1'b0);
    send_char(" ", 1'b0, 1'b0);
    // hex with both letter cases
    send_char("0", 1'b1, 1'b0);
    send_char("x", 1'b0, 1'b0);
    send_char("f", 1'b0, 1'b0);
    send_char("F", 1'b0, 1'b0);
    send_char(";", 1'b0, 1'b0);
    // binary ended by a digit too large
    send_char("0", 1'b1, 1'b0);
    send_char("B", 1'b0, 1'b0);
    send_char("1", 1'b0, 1'b0);
    send_char("0", 1'b0, 1'b0);
    send_char("2", 1'b0, 1'b0);
    // octal ended by a digit too large
    send_char("0", 1'b1, 1'b0);
    send_char("7", 1'b0, 1'b0);
    send_char("8", 1'b0, 1'b0);
    // hex letter as a decimal digit; non-digit first
    send_char("a", 1'b1, 1'b0);
    send_char(" ", 1'b1, 1'b0);
    // character while idle is dropped
    send_char("5", 1'b0, 1'b1);
    // restart abandons the literal in progress
    send_char("5", 1'b1, 1'b0);
    send_char("3", 1'b1, 1'b0);
    send_char(",", 1'b0, 1'b0);
    // byte extremes
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b0);
    drain_results();

    while (chars_sent < 600) begin
      no_idle = ($urandom_range(0, 5) == 0);
      send_literal();
      if (!paused && chars_sent >= 300) begin
        paused = 1'b1;
        drain_results();
      end
    end
    no_idle = 1'b0;
    drain_results();

    if (fail_count == 0 && results_due == 0)
      $display("[integer_literal_scanner_top] OK");
    else
      $display("[integer_literal_scanner_top] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lis_pkg.sv
hw/rtl/lis_if.sv
hw/rtl/lis_step.sv
hw/rtl/integer_literal_scanner_top.sv
sim/lis_scan_checker.sv
sim/tb_top.sv
